// ===== rtl/ctle_pkg.sv =====
// shared types and constants for the lru connection table
// no dependencies
`default_nettype none
package ctle_pkg;

  localparam int DEF_DEPTH = 64;
  // the max entries register is 7 bits wide, so no slot above this is ever used
  localparam int MAX_REG = 127;

  localparam logic [31:0] USE_DIV   = 32'd16;
  localparam logic [31:0] USE_FULL  = 32'hFFFF_FFFF;
  localparam logic [31:0] RESCALE_D = USE_FULL - USE_FULL / USE_DIV;

  localparam logic [2:0] FN_ADD    = 3'd0;
  localparam logic [2:0] FN_REMOVE = 3'd1;
  localparam logic [2:0] FN_RECORD = 3'd2;
  localparam logic [2:0] FN_LOOKUP = 3'd3;
  localparam logic [2:0] FN_CHECK  = 3'd4;
  localparam logic [2:0] FN_CLEAR  = 3'd5;

  localparam logic [2:0] ST_ADDED      = 3'd0;
  localparam logic [2:0] ST_REJECTED   = 3'd1;
  localparam logic [2:0] ST_REMOVED    = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd3;
  localparam logic [2:0] ST_FOUND      = 3'd4;
  localparam logic [2:0] ST_RESV_OTHER = 3'd5;
  localparam logic [2:0] ST_RESV_NOW   = 3'd6;
  localparam logic [2:0] ST_DONE       = 3'd7;

  typedef struct packed {
    logic [2:0]  func;
    logic [15:0] handle;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [15:0] peer_port;
    logic [1:0]  ip_kind;
    logic        unique_only;
    logic        reject_if_full;
    logic [63:0] now_us;
  } ctle_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] result_handle;
    logic        evict_valid;
    logic [15:0] evict_handle;
    logic [63:0] found_addr_hi;
    logic [63:0] found_addr_lo;
    logic [15:0] found_port;
    logic [1:0]  found_kind;
  } ctle_out_t;

  typedef struct packed {
    logic [15:0] handle;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [17:0] port_kind;
    logic [31:0] last_use;
  } ctle_entry_t;

  typedef struct packed {
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [17:0] port_kind;
    logic [63:0] stamp;
  } ctle_resv_t;

  typedef struct packed {
    logic      valid;
    ctle_out_t item;
  } ctle_res_t;

  typedef enum logic [3:0] {
    S_IDLE, S_ESCAN, S_RSCAN, S_SLOT_RD, S_SLOT_WR,
    S_MOVE_RD, S_MOVE_WR, S_RES_WR, S_DONE
  } ctle_state_t;

endpackage
`default_nettype wire

// ===== rtl/ctle_ram.sv =====
// generic single write, single read ram with registered read data
// no dependencies
`default_nettype none
module ctle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/ctle_ctrl.sv =====
// sequencer for the connection and reservation tables: scans, read-modify-write
// depends on ctle_pkg; drives the two ctle_ram instances in the top level
`default_nettype none
module ctle_ctrl #(
  parameter int DEPTH = ctle_pkg::DEF_DEPTH,
  localparam int USED = (DEPTH < ctle_pkg::MAX_REG) ? DEPTH : ctle_pkg::MAX_REG,
  localparam int AW = $clog2(USED)
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [6:0]           cfg_wdata,
  input  wire logic                 in_valid,
  input  wire ctle_pkg::ctle_in_t   in_item,
  output logic                      ready,
  output logic                      e_we,
  output logic [AW-1:0]             e_waddr,
  output ctle_pkg::ctle_entry_t     e_wdata,
  output logic [AW-1:0]             e_raddr,
  input  wire ctle_pkg::ctle_entry_t e_rdata,
  output logic                      r_we,
  output logic [AW-1:0]             r_waddr,
  output ctle_pkg::ctle_resv_t      r_wdata,
  output logic [AW-1:0]             r_raddr,
  input  wire ctle_pkg::ctle_resv_t r_rdata,
  output ctle_pkg::ctle_res_t       res,
  input  wire logic                 out_free
);
  import ctle_pkg::*;

  localparam int CW = $clog2(USED + 1);

  ctle_state_t st, st_next;
  ctle_in_t    it;
  ctle_out_t   rs;
  logic [CW-1:0] cnt, sc, m_eff, limit;
  logic [6:0]    maxr;
  logic [31:0]   ucnt;
  logic          wrap;
  logic          pv;
  logic [AW-1:0] pidx, idx, slot, wslot;
  logic [USED-1:0] e_vld, r_vld;
  logic          m_have;
  logic [15:0]   m_handle, lru_handle;
  logic [AW-1:0] m_idx, lru_idx, free_idx, old_idx;
  logic [31:0]   lru_stamp;
  logic          free_found;
  logic [63:0]   oldest;

  logic [17:0]   key_pk;
  logic [31:0]   e_stamp, rec_stamp, slot_stamp;
  logic          e_key_hit, e_h_hit, r_key_hit, r_free;
  logic          add_uniq, issue, scan_end, room, do_reject;
  logic [2:0]    first_st;
  ctle_resv_t    rr;
  ctle_entry_t   mv;

  always_comb begin
    if (maxr == 7'd0) begin
      m_eff = CW'(1);
    end else if (int'(maxr) > USED) begin
      m_eff = CW'(USED);
    end else begin
      m_eff = CW'(maxr);
    end
  end

  assign key_pk    = {it.ip_kind, it.peer_port};
  assign add_uniq  = (it.ip_kind != 2'd0) && it.unique_only;
  assign room      = cnt < m_eff;
  assign do_reject = (in_item.func == FN_ADD) && !room && in_item.reject_if_full;

  // status an item starts out with
  always_comb begin
    if (do_reject) begin
      first_st = ST_REJECTED;
    end else if (in_item.func == FN_REMOVE || in_item.func == FN_LOOKUP) begin
      first_st = ST_NOT_FOUND;
    end else begin
      first_st = ST_DONE;
    end
  end

  // stamps of never written slots read as zero
  assign e_stamp   = e_vld[pidx] ? e_rdata.last_use : 32'd0;
  assign e_key_hit = (e_rdata.addr_hi == it.addr_hi) && (e_rdata.addr_lo == it.addr_lo) &&
                     (e_rdata.port_kind == key_pk);
  assign e_h_hit   = e_rdata.handle == it.handle;
  assign rr        = r_vld[pidx] ? r_rdata : '0;
  assign r_key_hit = (rr.addr_hi == it.addr_hi) && (rr.addr_lo == it.addr_lo) &&
                     (rr.port_kind == key_pk);
  assign r_free    = (rr.addr_hi == 64'd0) && (rr.addr_lo == 64'd0) && (rr.port_kind == 18'd0);

  assign limit    = (st == S_RSCAN) ? m_eff : cnt;
  assign issue    = sc < limit;
  assign scan_end = !pv && !issue;

  assign slot  = m_have ? m_idx : (room ? cnt[AW-1:0] : lru_idx);
  assign wslot = free_found ? free_idx : old_idx;

  always_comb begin
    if (e_h_hit) begin
      rec_stamp = ucnt;
    end else if (wrap) begin
      rec_stamp = (e_stamp > RESCALE_D) ? e_stamp - RESCALE_D : 32'd0;
    end else begin
      rec_stamp = e_stamp;
    end
  end

  assign slot_stamp = e_vld[idx] ? e_rdata.last_use : 32'd0;

  always_comb begin
    mv = e_rdata;
    mv.last_use = e_vld[cnt[AW-1:0]] ? e_rdata.last_use : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_comb begin
    st_next = st;
    ready   = 1'b0;
    e_we    = 1'b0;
    e_waddr = pidx;
    e_wdata = e_rdata;
    e_raddr = sc[AW-1:0];
    r_we    = 1'b0;
    r_waddr = wslot;
    r_wdata = '{addr_hi: it.addr_hi, addr_lo: it.addr_lo, port_kind: key_pk, stamp: it.now_us};
    r_raddr = sc[AW-1:0];
    unique case (st)
      S_IDLE: begin
        ready = 1'b1;
        if (in_valid) begin
          if (do_reject) begin
            st_next = S_DONE;
          end else begin
            case (in_item.func) inside
              FN_ADD, FN_REMOVE, FN_RECORD, FN_LOOKUP, FN_CHECK: st_next = S_ESCAN;
              FN_CLEAR: st_next = S_RSCAN;
              default:  st_next = S_DONE;
            endcase
          end
        end
      end
      S_ESCAN: begin
        case (it.func)
          FN_REMOVE: begin
            if (pv && e_h_hit) begin
              st_next = (CW'(pidx) < cnt - CW'(1)) ? S_MOVE_RD : S_DONE;
            end else if (scan_end) begin
              st_next = S_DONE;
            end
          end
          FN_CHECK: begin
            if (pv && e_key_hit) begin
              st_next = S_DONE;
            end else if (scan_end) begin
              st_next = S_RSCAN;
            end
          end
          FN_RECORD: begin
            e_we = pv;
            e_wdata.last_use = rec_stamp;
            if (scan_end) begin
              st_next = S_DONE;
            end
          end
          FN_ADD: begin
            if (scan_end) begin
              st_next = (it.ip_kind != 2'd0) ? S_RSCAN : S_SLOT_RD;
            end
          end
          default: begin
            if (scan_end) begin
              st_next = S_DONE;
            end
          end
        endcase
      end
      S_RSCAN: begin
        if (it.func == FN_CHECK) begin
          if (pv && r_key_hit) begin
            st_next = S_DONE;
          end else if (scan_end) begin
            st_next = S_RES_WR;
          end
        end else if (scan_end) begin
          st_next = (it.func == FN_ADD) ? S_SLOT_RD : S_DONE;
        end
      end
      S_SLOT_RD: begin
        e_raddr = slot;
        st_next = S_SLOT_WR;
      end
      S_SLOT_WR: begin
        e_we    = 1'b1;
        e_waddr = idx;
        if (it.ip_kind != 2'd0) begin
          e_wdata = '{handle: it.handle, addr_hi: it.addr_hi, addr_lo: it.addr_lo,
                      port_kind: key_pk, last_use: slot_stamp};
        end else begin
          e_wdata = '{handle: it.handle, addr_hi: 64'd0, addr_lo: 64'd0,
                      port_kind: 18'd0, last_use: slot_stamp};
        end
        st_next = S_DONE;
      end
      S_MOVE_RD: begin
        e_raddr = cnt[AW-1:0];
        st_next = S_MOVE_WR;
      end
      S_MOVE_WR: begin
        e_we    = 1'b1;
        e_waddr = idx;
        e_wdata = mv;
        st_next = S_DONE;
      end
      S_RES_WR: begin
        r_we    = 1'b1;
        st_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          st_next = S_IDLE;
        end
      end
      default: st_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      maxr  <= 7'd64;
      ucnt  <= 32'd0;
      e_vld <= '0;
      r_vld <= '0;
      pv    <= 1'b0;
      sc    <= '0;
    end else begin
      if (cfg_we) begin
        maxr <= cfg_wdata;
      end
      if (st_next != st) begin
        sc <= '0;
        pv <= 1'b0;
      end else if ((st == S_ESCAN || st == S_RSCAN) && issue) begin
        sc   <= sc + CW'(1);
        pv   <= 1'b1;
        pidx <= sc[AW-1:0];
      end else begin
        pv <= 1'b0;
      end

      unique case (st)
        S_IDLE: begin
          if (in_valid) begin
            it         <= in_item;
            rs         <= '{status: first_st, result_handle: 16'd0, evict_valid: 1'b0,
                            evict_handle: 16'd0, found_addr_hi: 64'd0,
                            found_addr_lo: 64'd0, found_port: 16'd0, found_kind: 2'd0};
            m_have     <= 1'b0;
            free_found <= 1'b0;
            oldest     <= in_item.now_us;
            old_idx    <= '0;
            if (in_item.func == FN_RECORD) begin
              wrap <= ucnt == USE_FULL;
              ucnt <= (ucnt == USE_FULL) ? ucnt - RESCALE_D + 32'd1 : ucnt + 32'd1;
            end
          end
        end
        S_ESCAN: begin
          if (pv) begin
            case (it.func)
              FN_ADD: begin
                if (add_uniq && e_key_hit && !m_have) begin
                  m_have   <= 1'b1;
                  m_idx    <= pidx;
                  m_handle <= e_rdata.handle;
                end
                if (pidx == '0 || e_stamp < lru_stamp) begin
                  lru_idx    <= pidx;
                  lru_stamp  <= e_stamp;
                  lru_handle <= e_rdata.handle;
                end
              end
              FN_REMOVE: begin
                if (e_h_hit) begin
                  rs.status <= ST_REMOVED;
                  idx       <= pidx;
                  cnt       <= cnt - CW'(1);
                end
              end
              FN_RECORD: e_vld[pidx] <= 1'b1;
              FN_LOOKUP: begin
                if (e_h_hit) begin
                  rs.status        <= ST_FOUND;
                  rs.found_addr_hi <= e_rdata.addr_hi;
                  rs.found_addr_lo <= e_rdata.addr_lo;
                  rs.found_port    <= e_rdata.port_kind[15:0];
                  rs.found_kind    <= e_rdata.port_kind[17:16];
                end
              end
              FN_CHECK: begin
                if (e_key_hit) begin
                  rs.status        <= ST_FOUND;
                  rs.result_handle <= e_rdata.handle;
                end
              end
              default: ;
            endcase
          end
        end
        S_RSCAN: begin
          if (pv) begin
            if (it.func == FN_CHECK) begin
              if (r_key_hit) begin
                rs.status <= ST_RESV_OTHER;
              end else if (!free_found) begin
                if (r_free) begin
                  free_found <= 1'b1;
                  free_idx   <= pidx;
                end else if (rr.stamp < oldest) begin
                  oldest  <= rr.stamp;
                  old_idx <= pidx;
                end
              end
            end else if (r_key_hit) begin
              r_vld[pidx] <= 1'b0;
            end
          end
        end
        S_SLOT_RD: begin
          idx       <= slot;
          rs.status <= ST_ADDED;
          if (m_have) begin
            rs.evict_valid  <= 1'b1;
            rs.evict_handle <= m_handle;
          end else if (room) begin
            cnt <= cnt + CW'(1);
          end else begin
            rs.evict_valid  <= 1'b1;
            rs.evict_handle <= lru_handle;
          end
        end
        S_SLOT_WR, S_MOVE_WR: e_vld[idx] <= 1'b1;
        S_RES_WR: begin
          r_vld[wslot] <= 1'b1;
          rs.status    <= ST_RESV_NOW;
        end
        S_MOVE_RD, S_DONE: ;
        default: ;
      endcase
    end
  end

  assign res.valid = st == S_DONE;
  assign res.item  = rs;

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) int'(cnt) <= USED)
    else $error("entry count beyond table depth");
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (ready && in_valid) |=> !ready)
    else $error("second item taken while one is in work");
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (st == S_DONE && !out_free) |=> (st == S_DONE && $stable(rs)))
    else $error("result changed before it was handed off");
  a_slot_marked: assert property (@(posedge clk) disable iff (rst)
    (st == S_SLOT_WR) |=> e_vld[$past(idx)])
    else $error("written slot not marked valid");
endmodule
`default_nettype wire

// ===== rtl/connection_table_lru_evict_top.sv =====
// top level of the lru connection table: entry and reservation rams, sequencer,
// output register; depends on ctle_pkg, ctle_ram and ctle_ctrl
`default_nettype none
// Bounded table of connection handles with least-recently-used eviction and a
// table of address reservations. One item is in work at a time; the result is
// held in an output register so the next item can be taken while it waits.
// Both tables live in single-port-read synchronous rams and are walked one
// slot per cycle with the read pipelined, so the ram scans set how long an item
// takes: add walks the n entries in use and then the m effective max entries of
// reservations (without an address the reservation pass is skipped), check or
// reserve walks up to n entries and then up to m reservations, remove up to n
// entries, record usage and lookup all n, clear reservation all m; other codes
// and a rejected add walk nothing. A result may also wait on a stalled output.
// No clearing pass is needed after reset: per-slot valid flags make unwritten
// stamps and reservations read as zero.
module connection_table_lru_evict_top #(
  parameter int TABLE_DEPTH = ctle_pkg::DEF_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [6:0]          cfg_wdata,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire ctle_pkg::ctle_in_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output ctle_pkg::ctle_out_t      out_item
);
  import ctle_pkg::*;

  // slots above the 7-bit max entries register can never be used
  localparam int USED = (TABLE_DEPTH < MAX_REG) ? TABLE_DEPTH : MAX_REG;
  localparam int AW = $clog2(USED);

  logic          ready, out_free;
  ctle_res_t     res;
  logic          e_we, r_we;
  logic [AW-1:0] e_waddr, e_raddr, r_waddr, r_raddr;
  ctle_entry_t   e_wdata, e_rdata;
  ctle_resv_t    r_wdata, r_rdata;

  // sequencer takes an item only when idle
  assign in_stall = !ready;

  // output register frees the sequencer as soon as its result is captured
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && out_free) begin
      out_item <= res.item;
    end
  end

  // handle, key and last-use stamp of each connection entry
  ctle_ram #(.WIDTH($bits(ctle_entry_t)), .DEPTH(USED)) u_entry_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  // key and time stamp of each reservation
  ctle_ram #(.WIDTH($bits(ctle_resv_t)), .DEPTH(USED)) u_resv_ram (
    .clk   (clk),
    .we    (r_we),
    .waddr (r_waddr),
    .wdata (r_wdata),
    .raddr (r_raddr),
    .rdata (r_rdata)
  );

  ctle_ctrl #(.DEPTH(TABLE_DEPTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .ready     (ready),
    .e_we      (e_we),
    .e_waddr   (e_waddr),
    .e_wdata   (e_wdata),
    .e_raddr   (e_raddr),
    .e_rdata   (e_rdata),
    .r_we      (r_we),
    .r_waddr   (r_waddr),
    .r_wdata   (r_wdata),
    .r_raddr   (r_raddr),
    .r_rdata   (r_rdata),
    .res       (res),
    .out_free  (out_free)
  );
endmodule
`default_nettype wire

// ===== tb/ctle_checker.sv =====
// checker for the lru connection table: watches both channels and the config port,
// predicts each result and compares it; depends on ctle_pkg
`timescale 1ns / 1ps
module ctle_checker
  import ctle_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      cfg_we,
  input  wire logic [6:0] cfg_wdata,
  input  wire logic      in_valid,
  input  wire logic      in_stall,
  input  wire ctle_in_t  in_item,
  input  wire logic      out_valid,
  input  wire logic      out_stall,
  input  wire ctle_out_t out_item,
  output int             errors,
  output int             pending
);

  localparam int DEPTH = DEF_DEPTH;

  logic [6:0]  max_reg;
  int          conn_count;
  logic [15:0] conn_handle [DEPTH];
  logic [63:0] conn_hi [DEPTH];
  logic [63:0] conn_lo [DEPTH];
  logic [17:0] conn_pk [DEPTH];
  logic [31:0] conn_stamp [DEPTH];
  logic [31:0] use_ctr;
  logic [63:0] resv_hi [DEPTH];
  logic [63:0] resv_lo [DEPTH];
  logic [17:0] resv_pk [DEPTH];
  logic [63:0] resv_stamp [DEPTH];
  ctle_out_t   expected_q [$];

  assign pending = expected_q.size();

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    errors++;
  endtask

  function automatic int slots_in_use();
    if (max_reg < 1) return 1;
    if (max_reg > DEPTH) return DEPTH;
    return int'(max_reg);
  endfunction

  task automatic drop_reservations(input logic [63:0] hi, input logic [63:0] lo,
                                   input logic [17:0] pk);
    int m;
    m = slots_in_use();
    for (int i = 0; i < m; i++)
      if (resv_hi[i] == hi && resv_lo[i] == lo && resv_pk[i] == pk) begin
        resv_hi[i] = '0; resv_lo[i] = '0; resv_pk[i] = '0; resv_stamp[i] = '0;
      end
  endtask

  // applies one item to the table copy and returns the answer it gives
  task automatic apply_request(input ctle_in_t x, output ctle_out_t r);
    int n, m, idx, last;
    bit have, done;
    logic [63:0] hi, lo, oldest;
    logic [17:0] pk;
    logic [31:0] d;
    n = conn_count; m = slots_in_use();
    hi = x.addr_hi; lo = x.addr_lo; pk = {x.ip_kind, x.peer_port};
    r = '0;
    r.status = ST_DONE;
    case (x.func)
      FN_ADD: begin
        if (n >= m && x.reject_if_full) begin
          r.status = ST_REJECTED;
        end else begin
          idx = 0; have = 0;
          if (x.ip_kind != 0) begin
            if (x.unique_only)
              for (int i = 0; i < n; i++)
                if (conn_hi[i] == hi && conn_lo[i] == lo && conn_pk[i] == pk) begin
                  idx = i; have = 1; break;
                end
            drop_reservations(hi, lo, pk);
          end else begin
            hi = '0; lo = '0; pk = '0;
          end
          if (have) begin
            r.evict_valid = 1; r.evict_handle = conn_handle[idx];
          end else if (n < m) begin
            idx = n; conn_count = n + 1;
          end else begin
            // least recently used, lowest slot wins a tie
            idx = 0;
            for (int i = 1; i < n; i++)
              if (conn_stamp[i] < conn_stamp[idx]) idx = i;
            r.evict_valid = 1; r.evict_handle = conn_handle[idx];
          end
          conn_handle[idx] = x.handle; conn_hi[idx] = hi;
          conn_lo[idx] = lo; conn_pk[idx] = pk;
          r.status = ST_ADDED;
        end
      end
      FN_REMOVE: begin
        r.status = ST_NOT_FOUND;
        for (int i = 0; i < n; i++)
          if (conn_handle[i] == x.handle) begin
            last = n - 1;
            conn_count = last;
            if (i < last) begin
              conn_handle[i] = conn_handle[last]; conn_hi[i] = conn_hi[last];
              conn_lo[i] = conn_lo[last]; conn_pk[i] = conn_pk[last];
              conn_stamp[i] = conn_stamp[last];
            end
            r.status = ST_REMOVED;
            break;
          end
      end
      FN_RECORD: begin
        if (use_ctr == USE_FULL) begin
          d = use_ctr - use_ctr / USE_DIV;
          for (int i = 0; i < n; i++)
            conn_stamp[i] = (d < conn_stamp[i]) ? conn_stamp[i] - d : '0;
          use_ctr -= d;
        end
        use_ctr++;
        for (int i = 0; i < n; i++)
          if (conn_handle[i] == x.handle) conn_stamp[i] = use_ctr;
      end
      FN_LOOKUP: begin
        r.status = ST_NOT_FOUND;
        for (int i = 0; i < n; i++)
          if (conn_handle[i] == x.handle) begin
            r.status = ST_FOUND;
            r.found_addr_hi = conn_hi[i]; r.found_addr_lo = conn_lo[i];
            r.found_port = conn_pk[i][15:0]; r.found_kind = conn_pk[i][17:16];
          end
      end
      FN_CHECK: begin
        done = 0;
        for (int i = 0; i < n; i++)
          if (conn_hi[i] == hi && conn_lo[i] == lo && conn_pk[i] == pk) begin
            r.status = ST_FOUND; r.result_handle = conn_handle[i]; done = 1; break;
          end
        if (!done)
          for (int i = 0; i < m; i++)
            if (resv_hi[i] == hi && resv_lo[i] == lo && resv_pk[i] == pk) begin
              r.status = ST_RESV_OTHER; done = 1; break;
            end
        if (!done) begin
          // first free slot, else the oldest stamp strictly before now
          oldest = x.now_us; idx = 0;
          for (int i = 0; i < m; i++) begin
            if (resv_hi[i] == 0 && resv_lo[i] == 0 && resv_pk[i] == 0) begin
              idx = i; break;
            end
            if (resv_stamp[i] < oldest) begin
              oldest = resv_stamp[i]; idx = i;
            end
          end
          resv_hi[idx] = hi; resv_lo[idx] = lo; resv_pk[idx] = pk;
          resv_stamp[idx] = x.now_us;
          r.status = ST_RESV_NOW;
        end
      end
      FN_CLEAR: drop_reservations(hi, lo, pk);
      default: ;
    endcase
  endtask

  ctle_out_t want;

  always @(posedge clk) begin
    if (rst) begin
      max_reg = 7'd64; conn_count = 0; use_ctr = '0;
      for (int i = 0; i < DEPTH; i++) begin
        conn_handle[i] = '0; conn_hi[i] = '0; conn_lo[i] = '0; conn_pk[i] = '0;
        conn_stamp[i] = '0; resv_hi[i] = '0; resv_lo[i] = '0; resv_pk[i] = '0;
        resv_stamp[i] = '0;
      end
      expected_q.delete();
    end else begin
      if (cfg_we) max_reg = cfg_wdata;
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result item with nothing expected", $realtime);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (out_item.status != want.status)
            report("status", out_item.status, want.status);
          if (out_item.result_handle != want.result_handle)
            report("result_handle", out_item.result_handle, want.result_handle);
          if (out_item.evict_valid != want.evict_valid)
            report("evict_valid", out_item.evict_valid, want.evict_valid);
          if (out_item.evict_handle != want.evict_handle)
            report("evict_handle", out_item.evict_handle, want.evict_handle);
          if (out_item.found_addr_hi != want.found_addr_hi)
            report("found_addr_hi", out_item.found_addr_hi, want.found_addr_hi);
          if (out_item.found_addr_lo != want.found_addr_lo)
            report("found_addr_lo", out_item.found_addr_lo, want.found_addr_lo);
          if (out_item.found_port != want.found_port)
            report("found_port", out_item.found_port, want.found_port);
          if (out_item.found_kind != want.found_kind)
            report("found_kind", out_item.found_kind, want.found_kind);
        end
      end
      if (in_valid && !in_stall) begin
        apply_request(in_item, want);
        expected_q.push_back(want);
      end
    end
  end

  initial errors = 0;

endmodule

// ===== tb/tb_top.sv =====
// top of the lru connection table testbench: clock, reset, stimulus and verdict;
// depends on ctle_pkg, connection_table_lru_evict_top and ctle_checker
`timescale 1ns / 1ps
module tb_top;
  import ctle_pkg::*;

  logic      clk = 0;
  logic      rst = 1;
  logic      cfg_we = 0;
  logic [6:0] cfg_wdata = '0;
  logic      in_valid = 0;
  logic      in_stall;
  ctle_in_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 0;
  ctle_out_t out_item;
  int        errors;
  int        pending;

  // idle chances in percent, and the long receiver hold-off request
  int        send_idle_pct = 9;
  int        recv_idle_pct = 80;
  bit        hold_req = 0;

  // small pools so that keys and handles collide often
  logic [63:0] key_hi [8];
  logic [63:0] key_lo [8];
  logic [15:0] key_port [8];
  logic [63:0] clock_us = 64'd1000;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  connection_table_lru_evict_top dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  ctle_checker chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .errors(errors), .pending(pending)
  );

  // receiver: random stalls, or a long counted hold-off when asked
  initial begin
    int held;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1;
        for (held = 0; held < 400; held++) @(negedge clk);
        hold_req = 0;
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // offers one item, starting and ending at a falling edge; valid stays high
  // between back-to-back items
  task automatic offer(input ctle_in_t x);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_item <= x;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // sender pause: nothing in flight, then room for a last silent scan
  task automatic drain();
    in_valid <= 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  task automatic set_max(input logic [6:0] v);
    drain();
    cfg_we <= 1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 0;
    @(negedge clk);
  endtask

  function automatic ctle_in_t make_req(input logic [2:0] f, input logic [15:0] h,
                                        input int key, input logic [1:0] kind);
    ctle_in_t x;
    x = '0;
    x.func = f;
    x.handle = h;
    x.ip_kind = kind;
    if (key >= 0) begin
      x.addr_hi = key_hi[key]; x.addr_lo = key_lo[key]; x.peer_port = key_port[key];
    end
    x.now_us = clock_us;
    return x;
  endfunction

  function automatic ctle_in_t random_req();
    ctle_in_t x;
    int pick;
    pick = $urandom_range(99);
    x = make_req(FN_ADD, 16'd0, $urandom_range(7), 2'($urandom_range(1, 2)));
    if (pick < 30)      x.func = FN_ADD;
    else if (pick < 42) x.func = FN_REMOVE;
    else if (pick < 57) x.func = FN_RECORD;
    else if (pick < 69) x.func = FN_LOOKUP;
    else if (pick < 87) x.func = FN_CHECK;
    else if (pick < 95) x.func = FN_CLEAR;
    else                x.func = 3'($urandom_range(6, 7));
    x.handle = ($urandom_range(99) < 85) ? 16'($urandom_range(11)) : 16'($urandom);
    pick = $urandom_range(99);
    if (pick < 8) begin
      // unseen key, any kind, full-width address
      x.addr_hi = {$urandom, $urandom}; x.addr_lo = {$urandom, $urandom};
      x.peer_port = 16'($urandom); x.ip_kind = 2'($urandom);
    end else if (pick < 14) begin
      x.addr_hi = '0; x.addr_lo = '0; x.peer_port = '0; x.ip_kind = 2'd0;
    end
    x.unique_only = 1'($urandom_range(1));
    x.reject_if_full = ($urandom_range(99) < 30);
    if ($urandom_range(99) < 5) x.now_us = {$urandom, $urandom};
    else x.now_us = clock_us;
    return x;
  endfunction

  initial begin
    ctle_in_t x;
    logic [6:0] settings [8];
    settings = '{7'd3, 7'd1, 7'd127, 7'd0, 7'd5, 7'd64, 7'd16, 7'd2};
    for (int k = 0; k < 8; k++) begin
      key_hi[k] = {$urandom, $urandom};
      key_lo[k] = {$urandom, $urandom};
      key_port[k] = 16'($urandom);
    end
    key_hi[0] = '1; key_lo[0] = '1; key_port[0] = '1;
    key_hi[1] = '0; key_lo[1] = 64'h0000_0000_c0a8_0001; key_port[1] = '0;

    repeat (10) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // directed: adds of each kind, replace, lookups, removes, reservations
    offer(make_req(FN_ADD, 16'hffff, 0, 2'd2));
    offer(make_req(FN_ADD, 16'h0000, 1, 2'd1));
    offer(make_req(FN_ADD, 16'h0007, -1, 2'd0));
    x = make_req(FN_ADD, 16'h0005, 0, 2'd2);
    x.unique_only = 1;
    offer(x);
    offer(make_req(FN_ADD, 16'h0009, 2, 2'd3));
    offer(make_req(FN_LOOKUP, 16'h0005, -1, 2'd0));
    offer(make_req(FN_LOOKUP, 16'h1234, -1, 2'd0));
    offer(make_req(FN_RECORD, 16'h0000, -1, 2'd0));
    offer(make_req(FN_REMOVE, 16'h0000, -1, 2'd0));
    offer(make_req(FN_REMOVE, 16'h0000, -1, 2'd0));
    offer(make_req(FN_LOOKUP, 16'h0009, -1, 2'd0));
    offer(make_req(FN_CHECK, 16'h0000, 2, 2'd3));
    offer(make_req(FN_CHECK, 16'h0000, 3, 2'd1));
    offer(make_req(FN_CHECK, 16'h0000, 3, 2'd1));
    offer(make_req(FN_CHECK, 16'h0000, -1, 2'd0));
    offer(make_req(FN_CLEAR, 16'h0000, 3, 2'd1));
    x = make_req(3'd6, 16'hffff, 0, 2'd3);
    x.now_us = '1; x.unique_only = 1; x.reject_if_full = 1;
    offer(x);
    offer(make_req(3'd7, 16'h0000, -1, 2'd0));
    set_max(7'd2);
    x = make_req(FN_ADD, 16'h0011, 4, 2'd1);
    x.reject_if_full = 1;
    offer(x);
    offer(make_req(FN_RECORD, 16'h0005, -1, 2'd0));
    offer(make_req(FN_ADD, 16'h0012, 5, 2'd1));
    offer(make_req(FN_CHECK, 16'h0000, 6, 2'd2));
    offer(make_req(FN_CHECK, 16'h0000, 7, 2'd2));
    clock_us = clock_us + 5;
    offer(make_req(FN_CHECK, 16'h0000, 4, 2'd1));

    // random phases over several table sizes, idling modes by thirds
    for (int p = 0; p < 8; p++) begin
      set_max(settings[p]);
      for (int i = 0; i < 229; i++) begin
        int done_items;
        done_items = p * 229 + i;
        if (done_items < 610) begin
          send_idle_pct = 9; recv_idle_pct = 80;
        end else if (done_items < 1220) begin
          send_idle_pct = 80; recv_idle_pct = 9;
        end else begin
          send_idle_pct = 0; recv_idle_pct = 0;
        end
        // long receiver hold-off while items keep coming
        if (i == 100 && (p == 2 || p == 6)) hold_req = 1;
        if (i == 150) drain();
        clock_us = clock_us + $urandom_range(3);
        offer(random_req());
      end
    end

    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #30ms;
    $display("Verification failed");
    $finish;
  end

endmodule
